/* hw/rtl/bmb_pkg.sv */
// Package for the block mean binariser: image geometry, derived widths and the
// status record passed from the tile accumulator to the result stage.
// No dependencies.
package bmb_pkg;

   // Image geometry in tiles and pixels per tile edge
   localparam int TILE_SIZE = 5;
   localparam int GRID_ROWS = 15;
   localparam int GRID_COLS = 10;

   localparam int TILE_AREA = TILE_SIZE * TILE_SIZE;

   // Field widths
   localparam int PIXEL_W  = 8;
   localparam int THRESH_W = 8;
   localparam int TILE_IDX_W = 4;

   // Counter and accumulator widths
   localparam int XY_W    = $clog2(TILE_SIZE);
   localparam int COL_W   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int ROW_W   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int SUM_W   = $clog2(TILE_AREA * 255 + 1);
   localparam int LIMIT_W = $clog2(TILE_AREA * 256 + 1);

   // Threshold after reset
   localparam int THRESH_RESET = 200;

   // Finished-tile record from the accumulator
   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] sum;
      logic [ROW_W-1:0] trow;
      logic [COL_W-1:0] tcol;
   } tile_done_type;

endpackage

/* hw/rtl/block_mean_binarizer.sv */
// Block mean binariser top level: joins the tile accumulator and the result stage.
// Depends on bmb_pkg, bmb_accum and bmb_result.
//
// Takes one pixel per clock in raster order while req_ready is high, and issues one
// bit per 5x5 tile on the tile's bottom-right pixel: ink 1 when the tile's floor mean
// is at or below the threshold. The result appears in the cycle after that pixel is
// accepted, from a single result register; req_ready drops only while that register
// holds a result that rsp_ready does not take in the same cycle. frame_start restarts
// the raster position. Writing the threshold scales it once into a sum limit, so the
// compare needs no divider. No clearing pass after reset.
module block_mean_binarizer
   import bmb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [THRESH_W-1:0]   csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   input  logic                  req_frame_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ink,
   output logic [TILE_IDX_W-1:0] rsp_tile_row,
   output logic [TILE_IDX_W-1:0] rsp_tile_col,
   output logic                  rsp_last_tile
);

   logic          req_accept;
   tile_done_type tile_done;

   assign req_accept = req_valid && req_ready;

   // Accumulate pixels into column sums
   bmb_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .pixel       (req_pixel),
      .frame_start (req_frame_start),
      .tile_done   (tile_done)
   );

   // Threshold and register each finished tile
   bmb_result u_result (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .tile_done     (tile_done),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ink       (rsp_ink),
      .rsp_tile_row  (rsp_tile_row),
      .rsp_tile_col  (rsp_tile_col),
      .rsp_last_tile (rsp_last_tile)
   );

endmodule

/* hw/rtl/bmb_accum.sv */
// Tile accumulator: raster position counters and one running sum per tile column.
// Depends on bmb_pkg.
module bmb_accum
   import bmb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic               frame_start,
   output tile_done_type      tile_done
);

   logic [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [COL_W-1:0] tcol_ff, tcol_in;
   logic [ROW_W-1:0] trow_ff, trow_in;
   logic [SUM_W-1:0] sums_ff [GRID_COLS];

   logic [XY_W-1:0]  x_cur, y_cur;
   logic [COL_W-1:0] tcol_cur;
   logic [ROW_W-1:0] trow_cur;
   logic             first_px, last_px;
   logic [SUM_W-1:0] sum_new;

   // Restart the position at the top-left pixel on frame start
   always_comb begin
      x_cur    = frame_start ? '0 : x_ff;
      y_cur    = frame_start ? '0 : y_ff;
      tcol_cur = frame_start ? '0 : tcol_ff;
      trow_cur = frame_start ? '0 : trow_ff;
      first_px = (x_cur == '0) && (y_cur == '0);
      last_px  = (x_cur == XY_W'(TILE_SIZE - 1)) && (y_cur == XY_W'(TILE_SIZE - 1));
   end

   // Load the sum on a tile's first pixel, add elsewhere
   always_comb begin
      if (first_px) begin
         sum_new = SUM_W'(pixel);
      end else begin
         sum_new = sums_ff[tcol_cur] + SUM_W'(pixel);
      end
   end

   // Advance the raster position, wrapping at the image edges
   always_comb begin
      x_in    = x_cur;
      y_in    = y_cur;
      tcol_in = tcol_cur;
      trow_in = trow_cur;
      if (x_cur == XY_W'(TILE_SIZE - 1)) begin
         x_in = '0;
         if (tcol_cur == COL_W'(GRID_COLS - 1)) begin
            tcol_in = '0;
            if (y_cur == XY_W'(TILE_SIZE - 1)) begin
               y_in = '0;
               if (trow_cur == ROW_W'(GRID_ROWS - 1)) begin
                  trow_in = '0;
               end else begin
                  trow_in = trow_cur + 1'b1;
               end
            end else begin
               y_in = y_cur + 1'b1;
            end
         end else begin
            tcol_in = tcol_cur + 1'b1;
         end
      end else begin
         x_in = x_cur + 1'b1;
      end
   end

   // Hold position between requests
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
      end else if (accept) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
      end
   end

   // Write back the column sum
   always_ff @(posedge clock) begin
      if (accept) begin
         sums_ff[tcol_cur] <= sum_new;
      end
   end

   // Report a finished tile to the result stage
   always_comb begin
      tile_done.done = accept && last_px;
      tile_done.sum  = sum_new;
      tile_done.trow = trow_cur;
      tile_done.tcol = tcol_cur;
   end

endmodule

/* hw/rtl/bmb_result.sv */
// Result stage: threshold limit register, tile-mean compare and result register.
// Depends on bmb_pkg.
module bmb_result
   import bmb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [THRESH_W-1:0]   csr_wr_data,
   input  tile_done_type         tile_done,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ink,
   output logic [TILE_IDX_W-1:0] rsp_tile_row,
   output logic [TILE_IDX_W-1:0] rsp_tile_col,
   output logic                  rsp_last_tile
);

   // floor(sum / area) > thr  <=>  sum >= area * (thr + 1)
   localparam logic [LIMIT_W-1:0] LimitReset = LIMIT_W'(TILE_AREA * (THRESH_RESET + 1));

   logic [LIMIT_W-1:0]    limit_ff, limit_in;
   logic                  valid_ff, valid_in;
   logic                  ink_ff;
   logic [TILE_IDX_W-1:0] row_ff, col_ff;
   logic                  last_ff;

   // Scale the threshold into a sum limit on each write
   assign limit_in = LIMIT_W'(TILE_AREA) * (LIMIT_W'(csr_wr_data) + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_wr_en) begin
         limit_ff <= limit_in;
      end
   end

   // Take a new request unless a result waits unclaimed
   assign req_ready = !valid_ff || rsp_ready;

   always_comb begin
      if (tile_done.done) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the finished tile
   always_ff @(posedge clock) begin
      if (tile_done.done) begin
         ink_ff  <= (LIMIT_W'(tile_done.sum) < limit_ff);
         row_ff  <= TILE_IDX_W'(tile_done.trow);
         col_ff  <= TILE_IDX_W'(tile_done.tcol);
         last_ff <= (tile_done.trow == ROW_W'(GRID_ROWS - 1)) &&
                    (tile_done.tcol == COL_W'(GRID_COLS - 1));
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_ink       = ink_ff;
   assign rsp_tile_row  = row_ff;
   assign rsp_tile_col  = col_ff;
   assign rsp_last_tile = last_ff;

endmodule

/* hw/rtl/bmb_checker.sv */
// Port-level checks for the block mean binariser, bound to the top level.
// Depends on bmb_pkg and block_mean_binarizer.
module bmb_checker
   import bmb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_ink,
   input logic [TILE_IDX_W-1:0] rsp_tile_row,
   input logic [TILE_IDX_W-1:0] rsp_tile_col,
   input logic                  rsp_last_tile
);

   // Drop any result on reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ink) &&
         $stable(rsp_tile_row) && $stable(rsp_tile_col) && $stable(rsp_last_tile))
      else $error("stalled result changed");

   // No request while a result waits unclaimed
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken over a stalled result");

   // Last tile sits in the bottom-right grid position
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_tile |->
         rsp_tile_row == TILE_IDX_W'(GRID_ROWS - 1) &&
         rsp_tile_col == TILE_IDX_W'(GRID_COLS - 1))
      else $error("last tile flag at wrong position");

endmodule

bind block_mean_binarizer bmb_checker u_bmb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_ink       (rsp_ink),
   .rsp_tile_row  (rsp_tile_row),
   .rsp_tile_col  (rsp_tile_col),
   .rsp_last_tile (rsp_last_tile)
);
